@@ rtl/sdhs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sdhs_pkg;

    // Sequencer states: collect requests, add the three fixed positions, emit.
    typedef enum logic [4:0] {
        ST_COLLECT  = 5'b00001,
        ST_ADD_HEAD = 5'b00010,
        ST_ADD_ZERO = 5'b00100,
        ST_ADD_TOP  = 5'b01000,
        ST_EMIT     = 5'b10000
    } state_t;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_CYLINDER_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEAD_START     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SWEEP_UP       = 2'd2;

    // Register values after reset.
    localparam int unsigned RST_CYLINDER_COUNT = 200;
    localparam int unsigned RST_HEAD_START     = 0;
    localparam logic        RST_SWEEP_UP       = 1'b1;

endpackage

`default_nettype wire

@@ rtl/sdhs_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

// One slot of the sorted chain. On an insert, a slot whose value is above the
// new one (or that is empty) takes its left neighbor's value, or the new value
// if the neighbor stays put.
module sdhs_cell #(
    parameter int unsigned W = 16
) (
    input  wire logic         aclk,
    input  wire logic         ins_en,
    input  wire logic [W-1:0] ins_val,
    input  wire logic         occ,
    input  wire logic         left_gt,
    input  wire logic [W-1:0] left_val,
    output logic      [W-1:0] val,
    output logic              gt
);

    logic [W-1:0] val_reg;
    logic [W-1:0] val_next;

    assign gt  = !occ || (val_reg > ins_val);
    assign val = val_reg;

    always_comb begin
        val_next = val_reg;
        if (ins_en && gt) begin
            val_next = left_gt ? left_val : ins_val;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

endmodule

`default_nettype wire

@@ rtl/sdhs_chain.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Row of sorting cells kept in ascending order, with one read port.
module sdhs_chain #(
    parameter int unsigned DEPTH = 19,
    parameter int unsigned W     = 16,
    localparam int unsigned FILL_W = $clog2(DEPTH + 1),
    localparam int unsigned IDX_W  = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              ins_en,
    input  wire logic [W-1:0]      ins_val,
    input  wire logic [FILL_W-1:0] fill,
    input  wire logic [IDX_W-1:0]  rd_idx,
    output logic      [W-1:0]      rd_val
);

    logic [W-1:0] vals [DEPTH];
    logic         gts  [DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic         occ;
        logic         left_gt;
        logic [W-1:0] left_val;

        assign occ = FILL_W'(i) < fill;

        if (i == 0) begin : g_first
            assign left_gt  = 1'b0;
            assign left_val = ins_val;
        end else begin : g_rest
            assign left_gt  = gts[i-1];
            assign left_val = vals[i-1];
        end

        sdhs_cell #(
            .W (W)
        ) u_cell (
            .aclk     (aclk),
            .ins_en   (ins_en),
            .ins_val  (ins_val),
            .occ      (occ),
            .left_gt  (left_gt),
            .left_val (left_val),
            .val      (vals[i]),
            .gt       (gts[i])
        );
    end

    assign rd_val = vals[rd_idx];

endmodule

`default_nettype wire

@@ rtl/scan_disk_head_scheduler.sv @@
`timescale 1ns / 1ps
`default_nettype none

// SCAN (elevator) disk head scheduler.
// Input channel (s_*): one request cylinder per transfer; s_final_request marks
// the last request of a batch. Requests above the top cylinder saturate to it,
// and requests past MAX_REQUESTS are dropped (a dropped final still closes the
// batch). Each accepted request is sorted into a row of cells. After the final
// transfer the block adds the head, cylinder 0 and the top cylinder to the
// chain in the states ST_ADD_HEAD, ST_ADD_ZERO and ST_ADD_TOP, then emits
// count+3 results on the m_* channel, one per cycle while m_ready is high:
// head first, toward the chosen end, then reversing. m_total_seek is nonzero
// only with m_end_of_sequence.
// The input is held off (s_ready low) from the final transfer until the last
// result has been loaded into the output register; a stalled receiver simply
// holds the output register and pauses emission.
// Configuration (cfg_*) is for the user to write only while the block is idle
// (not enforced here), one register per cycle with cfg_wr_en. Reset clears the
// batch and loads the register defaults (200 cylinders, head 0, sweep upward).
module scan_disk_head_scheduler #(
    parameter int unsigned MAX_REQUESTS  = 16,
    parameter int unsigned CYLINDER_BITS = 16,
    localparam int unsigned CFG_W = CYLINDER_BITS + 1,
    localparam int unsigned CNT_W = $clog2(MAX_REQUESTS + 1)
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration
    input  wire logic                                cfg_wr_en,
    input  wire logic [sdhs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [CFG_W-1:0]                    cfg_wdata,
    // request channel
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [CYLINDER_BITS-1:0]            s_request_cylinder,
    input  wire logic                                s_final_request,
    // visit channel
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic      [CYLINDER_BITS-1:0]            m_visit_cylinder,
    output logic                                     m_end_of_sequence,
    output logic      [CYLINDER_BITS:0]              m_total_seek,
    output logic      [CNT_W-1:0]                    m_requests_served
);

    localparam int unsigned DEPTH  = MAX_REQUESTS + 3;
    localparam int unsigned FILL_W = $clog2(DEPTH + 1);
    localparam int unsigned IDX_W  = $clog2(DEPTH);
    localparam int unsigned CB     = CYLINDER_BITS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] cyl_count_reg;
    logic [CB-1:0]    head_start_reg;
    logic             sweep_up_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cyl_count_reg  <= CFG_W'(sdhs_pkg::RST_CYLINDER_COUNT);
            head_start_reg <= CB'(sdhs_pkg::RST_HEAD_START);
            sweep_up_reg   <= sdhs_pkg::RST_SWEEP_UP;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                sdhs_pkg::REG_CYLINDER_COUNT: cyl_count_reg  <= cfg_wdata;
                sdhs_pkg::REG_HEAD_START:     head_start_reg <= cfg_wdata[CB-1:0];
                sdhs_pkg::REG_SWEEP_UP:       sweep_up_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Top cylinder: count - 1, zero for an empty disk, saturated to the
    // largest cylinder the position width can hold.
    logic [CB-1:0] top_cyl;
    logic [CB-1:0] req_sat;

    always_comb begin
        if (cyl_count_reg[CB]) begin
            top_cyl = '1;
        end else if (cyl_count_reg == '0) begin
            top_cyl = '0;
        end else begin
            top_cyl = cyl_count_reg[CB-1:0] - CB'(1);
        end
    end

    assign req_sat = (s_request_cylinder > top_cyl) ? top_cyl : s_request_cylinder;

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    sdhs_pkg::state_t state_reg, state_next;
    logic [FILL_W-1:0] fill_reg, fill_next;     // occupied cells
    logic [IDX_W-1:0]  lt_reg, lt_next;         // positions below the head
    logic [IDX_W-1:0]  h_reg, h_next;           // head index in the chain
    logic [IDX_W-1:0]  idx_reg, idx_next;       // emission read index
    logic              asc_reg, asc_next;
    logic              second_reg, second_next;
    logic              first_reg, first_next;
    logic [CB-1:0]     prev_reg, prev_next;
    logic [CB:0]       total_reg, total_next;
    logic [CNT_W-1:0]  served_reg, served_next;

    logic              m_valid_reg, m_valid_next;
    logic [CB-1:0]     visit_reg;
    logic              eos_reg;
    logic [CB:0]       seek_reg;
    logic [CNT_W-1:0]  m_served_reg;

    logic              s_xfer;
    logic              out_load;
    logic              ins_en;
    logic [CB-1:0]     ins_val;
    logic [CB-1:0]     cur_val;
    logic [IDX_W-1:0]  last_idx;
    logic              at_top;
    logic              at_bot;
    logic              is_last;
    logic [CB-1:0]     step_dist;
    logic [CB:0]       seek_sum;

    assign s_ready  = (state_reg == sdhs_pkg::ST_COLLECT);
    assign s_xfer   = s_valid && s_ready;
    assign out_load = (state_reg == sdhs_pkg::ST_EMIT) && (!m_valid_reg || m_ready);

    sdhs_chain #(
        .DEPTH (DEPTH),
        .W     (CB)
    ) u_chain (
        .aclk    (aclk),
        .ins_en  (ins_en),
        .ins_val (ins_val),
        .fill    (fill_reg),
        .rd_idx  (idx_reg),
        .rd_val  (cur_val)
    );

    // Emission bookkeeping: where the sweep stands and the running seek.
    assign last_idx  = IDX_W'(fill_reg - FILL_W'(1));
    assign at_top    = (idx_reg == last_idx);
    assign at_bot    = (idx_reg == '0);
    assign is_last   = (asc_reg && at_top && (second_reg || (h_reg == '0)))
                    || (!asc_reg && at_bot && (second_reg || (h_reg == last_idx)));
    assign step_dist = first_reg ? '0
                     : ((cur_val >= prev_reg) ? (cur_val - prev_reg) : (prev_reg - cur_val));
    assign seek_sum  = total_reg + {1'b0, step_dist};

    always_comb begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        lt_next     = lt_reg;
        h_next      = h_reg;
        idx_next    = idx_reg;
        asc_next    = asc_reg;
        second_next = second_reg;
        first_next  = first_reg;
        prev_next   = prev_reg;
        total_next  = total_reg;
        served_next = served_reg;
        ins_en      = 1'b0;
        ins_val     = req_sat;

        unique case (state_reg)
            sdhs_pkg::ST_COLLECT: begin
                if (s_xfer) begin
                    // Drop requests once the batch is full.
                    ins_en = (fill_reg < FILL_W'(MAX_REQUESTS));
                    if (ins_en) begin
                        fill_next = fill_reg + FILL_W'(1);
                        lt_next   = lt_reg + IDX_W'(req_sat < head_start_reg);
                    end
                    if (s_final_request) begin
                        served_next = CNT_W'(fill_reg) + CNT_W'(ins_en);
                        state_next  = sdhs_pkg::ST_ADD_HEAD;
                    end
                end
            end
            sdhs_pkg::ST_ADD_HEAD: begin
                ins_en     = 1'b1;
                ins_val    = head_start_reg;
                fill_next  = fill_reg + FILL_W'(1);
                state_next = sdhs_pkg::ST_ADD_ZERO;
            end
            sdhs_pkg::ST_ADD_ZERO: begin
                ins_en     = 1'b1;
                ins_val    = '0;
                fill_next  = fill_reg + FILL_W'(1);
                lt_next    = lt_reg + IDX_W'(head_start_reg != '0);
                state_next = sdhs_pkg::ST_ADD_TOP;
            end
            sdhs_pkg::ST_ADD_TOP: begin
                ins_en      = 1'b1;
                ins_val     = top_cyl;
                fill_next   = fill_reg + FILL_W'(1);
                // Head index is the count of positions strictly below it.
                h_next      = lt_reg + IDX_W'(top_cyl < head_start_reg);
                idx_next    = lt_reg + IDX_W'(top_cyl < head_start_reg);
                lt_next     = '0;
                asc_next    = sweep_up_reg;
                second_next = 1'b0;
                first_next  = 1'b1;
                total_next  = '0;
                state_next  = sdhs_pkg::ST_EMIT;
            end
            sdhs_pkg::ST_EMIT: begin
                if (out_load) begin
                    prev_next  = cur_val;
                    total_next = seek_sum;
                    first_next = 1'b0;
                    if (is_last) begin
                        fill_next  = '0;
                        state_next = sdhs_pkg::ST_COLLECT;
                    end else if (asc_reg && at_top) begin
                        // Reverse below the head.
                        idx_next    = h_reg - IDX_W'(1);
                        asc_next    = 1'b0;
                        second_next = 1'b1;
                    end else if (!asc_reg && at_bot) begin
                        // Reverse above the head.
                        idx_next    = h_reg + IDX_W'(1);
                        asc_next    = 1'b1;
                        second_next = 1'b1;
                    end else if (asc_reg) begin
                        idx_next = idx_reg + IDX_W'(1);
                    end else begin
                        idx_next = idx_reg - IDX_W'(1);
                    end
                end
            end
            default: begin
                state_next = sdhs_pkg::ST_COLLECT;
            end
        endcase
    end

    // Output register: hold while the receiver stalls, drop valid once taken.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sdhs_pkg::ST_COLLECT;
            fill_reg    <= '0;
            lt_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            lt_reg      <= lt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        h_reg      <= h_next;
        idx_reg    <= idx_next;
        asc_reg    <= asc_next;
        second_reg <= second_next;
        first_reg  <= first_next;
        prev_reg   <= prev_next;
        total_reg  <= total_next;
        served_reg <= served_next;
        if (out_load) begin
            visit_reg    <= cur_val;
            eos_reg      <= is_last;
            seek_reg     <= is_last ? seek_sum : '0;
            m_served_reg <= served_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_visit_cylinder  = visit_reg;
    assign m_end_of_sequence = eos_reg;
    assign m_total_seek      = seek_reg;
    assign m_requests_served = m_served_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sdhs_pkg::ST_COLLECT) |-> (fill_reg <= FILL_W'(MAX_REQUESTS)))
        else $error("request count exceeds batch capacity");

    a_head_in_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sdhs_pkg::ST_EMIT) |-> (FILL_W'(h_reg) < fill_reg))
        else $error("head index outside the chain");

    a_idx_in_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sdhs_pkg::ST_EMIT) |-> (FILL_W'(idx_reg) < fill_reg))
        else $error("emission index outside the chain");

    a_last_returns: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && is_last) |=> (s_ready && (fill_reg == '0) && m_valid_reg))
        else $error("batch did not close after its last position");

    a_seek_only_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !eos_reg) |-> (seek_reg == '0))
        else $error("total seek shown before the final position");

endmodule

`default_nettype wire
